[rtl/rpr_pkg.sv]
package rpr_pkg;

  localparam int PAIRS_MAX_DEF     = 64;
  localparam int POS_MAX_DEF       = 4096;
  localparam int SAMPLE_WIDTH_DEF  = 24;
  localparam int CORDIC_STAGES_DEF = 18;

  localparam int GUARD_BITS   = 16;
  localparam int ATAN_ENTRIES = 30;

  // 1/K of the CORDIC gain in 2^-32 units, kept positive in a signed word.
  localparam logic signed [32:0] GAIN_INV = 33'sd2608131496;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ROT_FWD = 2'd1;
  localparam logic [1:0] OP_ROT_INV = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POS_RANGE  = 2'd1;
  localparam logic [1:0] ST_PAIR_RANGE = 2'd2;

  localparam logic CFG_PAIRS     = 1'b0;
  localparam logic CFG_POSITIONS = 1'b1;

  // Control that travels alongside each word in the pipeline.
  typedef struct packed {
    logic       valid;
    logic       rot;
    logic       inv;
    logic [1:0] status;
  } rpr_tag_t;

  // atan(2^-i) in 2^-32 turns, rounded to nearest.
  function automatic logic signed [31:0] atan_step(input int idx);
    logic signed [31:0] v;
    case (idx)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      20: v = 32'sd652;
      21: v = 32'sd326;
      22: v = 32'sd163;
      23: v = 32'sd81;
      24: v = 32'sd41;
      25: v = 32'sd20;
      26: v = 32'sd10;
      27: v = 32'sd5;
      28: v = 32'sd3;
      29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/rotary_position_rotator_core.sv]
// Channel   Direction  Handshake          Contents
// in_       input      in_valid/in_stall  opcode, position, pair, step, pair of samples
// out_      output     out_valid/out_stall rotated pair and status, one word per input
// cfg_      input      cfg_valid/cfg_ready pair and position limits, by register index
//
// One word enters per cycle unless the output stalls; the registered steps are the
// table read, phase and gain multiplies, quadrant fold, one CORDIC stage each, output.
// Reset clears the pipeline valid bits and sets the limits to PAIRS_MAX and POS_MAX.
// Table not cleared; the user must load entries before they are used, unchecked here.
// A stalled output word freezes the whole pipeline, and in_stall is raised meanwhile.
module rotary_position_rotator_core #(
  parameter int PAIRS_MAX     = rpr_pkg::PAIRS_MAX_DEF,
  parameter int POS_MAX       = rpr_pkg::POS_MAX_DEF,
  parameter int SAMPLE_WIDTH  = rpr_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = rpr_pkg::CORDIC_STAGES_DEF,
  localparam int PAIR_W   = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1,
  localparam int POS_W    = $clog2(POS_MAX),
  localparam int PCNT_W   = $clog2(PAIRS_MAX + 1),
  localparam int POSCNT_W = $clog2(POS_MAX + 1),
  localparam int CFG_W    = (PCNT_W > POSCNT_W) ? PCNT_W : POSCNT_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic [POS_W-1:0]               in_position,
  input  logic [PAIR_W-1:0]              in_pair_index,
  input  logic [31:0]                    in_phase_step,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x_first,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x_second,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_y_first,
  output logic signed [SAMPLE_WIDTH-1:0] out_y_second,
  output logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);
  import rpr_pkg::*;

  localparam int NS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int DW     = SAMPLE_WIDTH + GUARD_BITS + 2;
  localparam int PROD_W = SAMPLE_WIDTH + 33;
  localparam int HALF_I = 1 << (GUARD_BITS - 1);
  localparam logic signed [DW-1:0] SMAX =
    DW'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [DW-1:0] SMIN =
    DW'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));

  function automatic logic signed [DW-1:0] gain_comp(
    input logic signed [SAMPLE_WIDTH-1:0] x);
    logic signed [PROD_W-1:0] p;
    p = x * GAIN_INV;
    p = p + PROD_W'(HALF_I);
    return DW'(p >>> GUARD_BITS);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [DW-1:0] v);
    logic signed [DW-1:0] r;
    r = (v + DW'(HALF_I)) >>> GUARD_BITS;
    if (r > SMAX) begin
      r = SMAX;
    end else if (r < SMIN) begin
      r = SMIN;
    end
    return r[SAMPLE_WIDTH-1:0];
  endfunction

  logic en;
  logic accept;

  logic [PCNT_W-1:0]   pair_lim_r;
  logic [POSCNT_W-1:0] pos_lim_r;

  logic [31:0] freq_mem [PAIRS_MAX];

  // Accept cycle: limit checks and the table read.
  logic     pos_bad, pair_bad, is_rot;
  rpr_tag_t tag0;

  rpr_tag_t                      s1_tag_r;
  logic [POS_W-1:0]              s1_pos_r;
  logic [31:0]                   s1_step_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_x1_r, s1_x2_r;

  logic [POS_W+31:0] s1_prod;

  rpr_tag_t             s2_tag_r;
  logic [31:0]          s2_phase_r;
  logic signed [DW-1:0] s2_a_r, s2_b_r;

  logic [31:0]          s2_ph, s2_qsum;
  logic [1:0]           s2_q;
  logic signed [31:0]   s2_z;
  logic signed [DW-1:0] s2_a, s2_b;

  rpr_tag_t             c_tag_r;
  logic signed [DW-1:0] c_a_r, c_b_r;
  logic signed [31:0]   c_z_r;

  rpr_tag_t             co_tag;
  logic signed [DW-1:0] co_a, co_b;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_y_first_r, out_y_second_r;
  logic [1:0]                     out_status_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign accept    = in_valid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_lim_r <= PCNT_W'(PAIRS_MAX);
      pos_lim_r  <= POSCNT_W'(POS_MAX);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PAIRS:     pair_lim_r <= cfg_data[PCNT_W-1:0];
        CFG_POSITIONS: pos_lim_r  <= cfg_data[POSCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_bad  = (POSCNT_W'(in_position) >= pos_lim_r) ||
               (32'(in_position) >= 32'(POS_MAX));
    pair_bad = (PCNT_W'(in_pair_index) >= pair_lim_r) ||
               (32'(in_pair_index) >= 32'(PAIRS_MAX));
    is_rot   = (in_opcode == OP_ROT_FWD) || (in_opcode == OP_ROT_INV);
    tag0.valid = in_valid;
    tag0.inv   = (in_opcode == OP_ROT_INV);
    tag0.rot   = is_rot && !pos_bad && !pair_bad;
    if (is_rot && pos_bad) begin
      tag0.status = ST_POS_RANGE;
    end else if ((is_rot || (in_opcode == OP_LOAD)) && pair_bad) begin
      tag0.status = ST_PAIR_RANGE;
    end else begin
      tag0.status = ST_OK;
    end
  end

  // A load writes at the edge that accepts it, so a rotate in the next cycle sees it.
  always_ff @(posedge clk) begin
    if (accept && (in_opcode == OP_LOAD) && !pair_bad) begin
      freq_mem[in_pair_index] <= in_phase_step;
    end
    if (en) begin
      s1_step_r <= freq_mem[in_pair_index];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
    end else if (en) begin
      s1_tag_r <= tag0;
    end
    if (en) begin
      s1_pos_r <= in_position;
      s1_x1_r  <= in_x_first;
      s1_x2_r  <= in_x_second;
    end
  end

  assign s1_prod = s1_pos_r * s1_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r.valid <= 1'b0;
    end else if (en) begin
      s2_tag_r <= s1_tag_r;
    end
    if (en) begin
      s2_phase_r <= s1_prod[31:0];
      s2_a_r     <= gain_comp(s1_x1_r);
      s2_b_r     <= gain_comp(s1_x2_r);
    end
  end

  // Fold the phase into the quadrant nearest to it and a signed residual.
  always_comb begin
    s2_ph   = s2_tag_r.inv ? (32'd0 - s2_phase_r) : s2_phase_r;
    s2_qsum = s2_ph + 32'h2000_0000;
    s2_q    = s2_qsum[31:30];
    s2_z    = signed'(s2_ph - {s2_q, 30'd0});
    case (s2_q)
      2'd1: begin
        s2_a = -s2_b_r;
        s2_b = s2_a_r;
      end
      2'd2: begin
        s2_a = -s2_a_r;
        s2_b = -s2_b_r;
      end
      2'd3: begin
        s2_a = s2_b_r;
        s2_b = -s2_a_r;
      end
      default: begin
        s2_a = s2_a_r;
        s2_b = s2_b_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_tag_r.valid <= 1'b0;
    end else if (en) begin
      c_tag_r <= s2_tag_r;
    end
    if (en) begin
      c_a_r <= s2_a;
      c_b_r <= s2_b;
      c_z_r <= s2_z;
    end
  end

  rpr_cordic #(
    .DW (DW),
    .NS (NS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_tag  (c_tag_r),
    .in_a    (c_a_r),
    .in_b    (c_b_r),
    .in_z    (c_z_r),
    .out_tag (co_tag),
    .out_a   (co_a),
    .out_b   (co_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= co_tag.valid;
    end
    if (en) begin
      out_status_r <= co_tag.status;
      if (co_tag.rot) begin
        out_y_first_r  <= round_sat(co_a);
        out_y_second_r <= round_sat(co_b);
      end else begin
        out_y_first_r  <= '0;
        out_y_second_r <= '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_y_first  = out_y_first_r;
  assign out_y_second = out_y_second_r;
  assign out_status   = out_status_r;

  // Loads, errors and unused opcodes carry an all-zero pair; this checks error words.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |->
      (out_y_first_r == '0) && (out_y_second_r == '0))
    else $error("nonzero pair on a word with error status");

  // With no word waiting at the output the pipeline always takes input.
  a_no_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while the output is empty");

  // A word leaving the CORDIC is kept while the pipeline is frozen.
  a_cordic_hold: assert property (@(posedge clk) disable iff (!rst_n)
    co_tag.valid && !en |=> co_tag.valid)
    else $error("word lost in the CORDIC during a stall");

endmodule

[rtl/rpr_cordic.sv]
module rpr_cordic #(
  parameter int DW = 42,
  parameter int NS = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  rpr_pkg::rpr_tag_t      in_tag,
  input  logic signed [DW-1:0]   in_a,
  input  logic signed [DW-1:0]   in_b,
  input  logic signed [31:0]     in_z,
  output rpr_pkg::rpr_tag_t      out_tag,
  output logic signed [DW-1:0]   out_a,
  output logic signed [DW-1:0]   out_b
);
  import rpr_pkg::*;

  rpr_tag_t           tag_r [NS];
  logic signed [DW-1:0] a_r [NS];
  logic signed [DW-1:0] b_r [NS];
  // The last stage has no use for its angle residual.
  logic signed [31:0]   z_r [NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    rpr_tag_t             tag_p;
    logic signed [DW-1:0] a_p, b_p, a_nxt, b_nxt;
    logic signed [31:0]   z_p, z_nxt;

    if (k == 0) begin : g_first
      assign tag_p = in_tag;
      assign a_p   = in_a;
      assign b_p   = in_b;
      assign z_p   = in_z;
    end else begin : g_next
      assign tag_p = tag_r[k-1];
      assign a_p   = a_r[k-1];
      assign b_p   = b_r[k-1];
      assign z_p   = z_r[k-1];
    end

    // Both updates use the values from the previous stage.
    always_comb begin
      if (z_p >= 0) begin
        a_nxt = a_p - (b_p >>> k);
        b_nxt = b_p + (a_p >>> k);
        z_nxt = z_p - atan_step(k);
      end else begin
        a_nxt = a_p + (b_p >>> k);
        b_nxt = b_p - (a_p >>> k);
        z_nxt = z_p + atan_step(k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k].valid <= 1'b0;
      end else if (en) begin
        tag_r[k] <= tag_p;
      end
      if (en) begin
        a_r[k] <= a_nxt;
        b_r[k] <= b_nxt;
      end
    end

    if (k < NS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[k] <= z_nxt;
        end
      end
    end
  end

  assign out_tag = tag_r[NS-1];
  assign out_a   = a_r[NS-1];
  assign out_b   = b_r[NS-1];

endmodule
